// ===== hdl/mfrt_pkg.sv =====
package mfrt_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int ROW_BYTES   = SCREEN_WIDTH / 8;
  localparam int COL_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
  localparam int QUEUE_DEPTH = ROW_BYTES;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] LAST_SUB = 3'd7;

  typedef logic [6:0][7:0] stored_rows_t;

  typedef struct packed {
    logic [7:0][7:0] rows;
    logic            frame_last;
  } tile_t;

  function automatic logic [7:0] tile_column(input logic [7:0][7:0] rows,
                                             input logic [2:0] col);
    logic [7:0] result;
    for (int r = 0; r < 8; r++) begin
      result[r] = rows[r][col];
    end
    return result;
  endfunction

endpackage

// ===== hdl/mfrt_ifs.sv =====
interface mfrt_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       frame_start;

  modport source(output valid, output pixel_byte, output frame_start, input ready);
  modport sink(input valid, input pixel_byte, input frame_start, output ready);
endinterface

interface mfrt_column_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_byte;
  logic       tile_last;
  logic       frame_end;

  modport source(output valid, output column_byte, output tile_last, output frame_end,
                 input ready);
  modport sink(input valid, input column_byte, input tile_last, input frame_end,
               output ready);
endinterface

// ===== hdl/mfrt_front.sv =====
module mfrt_front
  import mfrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mfrt_pixel_if.sink         pixels,
  output logic               tile_valid,
  input  logic               tile_ready,
  output tile_t              tile
);

  stored_rows_t row_mem [ROW_BYTES];

  logic [COL_W-1:0] byte_column;
  logic [ROW_W-1:0] row_position;
  logic [COL_W-1:0] byte_column_next;
  logic [ROW_W-1:0] row_position_next;

  logic             s1_valid;
  logic [7:0]       s1_px;
  logic             s1_last;
  stored_rows_t     rd_rows;

  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [2:0]       sub;
  logic             accept;
  logic             push;
  logic             col_end;
  logic             row_end;

  assign col_cur = pixels.frame_start ? '0 : byte_column;
  assign row_cur = pixels.frame_start ? '0 : row_position;
  assign sub     = row_cur[2:0];
  assign col_end = (col_cur == COL_W'(ROW_BYTES - 1));
  assign row_end = (row_cur == ROW_W'(SCREEN_HEIGHT - 1));

  assign push         = s1_valid && tile_ready;
  assign pixels.ready = !s1_valid || tile_ready;
  assign accept       = pixels.valid && pixels.ready;

  always_comb begin
    if (col_end) begin
      byte_column_next  = '0;
      row_position_next = row_end ? '0 : row_cur + ROW_W'(1);
    end else begin
      byte_column_next  = col_cur + COL_W'(1);
      row_position_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column  <= '0;
      row_position <= '0;
    end else if (accept) begin
      byte_column  <= byte_column_next;
      row_position <= row_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sub != LAST_SUB) begin
      row_mem[col_cur][sub] <= pixels.pixel_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sub == LAST_SUB) begin
      rd_rows <= row_mem[col_cur];
      s1_px   <= pixels.pixel_byte;
      s1_last <= row_end && col_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && sub == LAST_SUB) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  assign tile_valid      = s1_valid;
  assign tile.rows       = {s1_px, rd_rows};
  assign tile.frame_last = s1_last;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> (s1_valid && !tile_ready))
    else $error("pixel request stalled without a pending tile");

  a_tile_holds: assert property (@(posedge clk) disable iff (rst)
    (tile_valid && !tile_ready) |=> (tile_valid && $stable(tile)))
    else $error("pending tile changed before it was queued");

endmodule

// ===== hdl/mfrt_tile_fifo.sv =====
module mfrt_tile_fifo
  import mfrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  tile_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output tile_t pop_data
);

  tile_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("tile queue count did not follow a push");

endmodule

// ===== hdl/mfrt_back.sv =====
module mfrt_back
  import mfrt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          tile_valid,
  output logic          tile_ready,
  input  tile_t         tile,
  mfrt_column_if.source columns
);

  tile_t      cur;
  logic       busy;
  logic [2:0] idx;
  logic       emit;
  logic       load;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_tile_last;
  logic       out_frame_end;

  assign emit       = busy && (!out_valid || columns.ready);
  assign tile_ready = !busy || (emit && idx == LAST_SUB);
  assign load       = tile_valid && tile_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && idx == LAST_SUB) begin
        busy <= 1'b0;
      end
      if (emit) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= tile;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (columns.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= tile_column(cur.rows, idx);
      out_tile_last <= (idx == LAST_SUB);
      out_frame_end <= (idx == LAST_SUB) && cur.frame_last;
    end
  end

  assign columns.valid       = out_valid;
  assign columns.column_byte = out_byte;
  assign columns.tile_last   = out_tile_last;
  assign columns.frame_end   = out_frame_end;

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == 3'd0))
    else $error("column index left nonzero while no tile is held");

  a_eighth_marks_last: assert property (@(posedge clk) disable iff (rst)
    (emit && idx == LAST_SUB) |=> (columns.valid && columns.tile_last))
    else $error("eighth column of a tile was not marked last");

  a_frame_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (columns.valid && columns.frame_end) |-> columns.tile_last)
    else $error("frame end raised on a column that does not close a tile");

endmodule

// ===== hdl/mono_frame_row_to_page_transpose_unit.sv =====
// Turns a one-bit-per-pixel frame sent as row-major bytes (bit 0 leftmost) into
// page-major column bytes (bit 0 topmost), one pixel request and one column
// request per cycle sustained while the column sink stays ready. The first
// seven rows of each eight-row page are held in a row store of SCREEN_WIDTH/8
// words, each word holding one byte from each of those seven rows. Each byte
// of a page's eighth row is accepted, reads the store into a registered tile,
// and that tile enters a tile queue one row long once the queue has room; the
// back part takes one tile at a time and sends its eight column bytes at one
// per cycle while the column sink is ready. Pixel requests stall only when that
// queue is full and a tile waits to enter it. The store has no reset, so a
// page's tiles are correct only once its first seven rows have been sent;
// frame_start restarts the position at the top left.
module mono_frame_row_to_page_transpose_unit
  import mfrt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mfrt_pixel_if.sink    pixels,
  mfrt_column_if.source columns
);

  logic  push_valid;
  logic  push_ready;
  tile_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  tile_t pop_data;

  mfrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .tile_valid (push_valid),
    .tile_ready (push_ready),
    .tile       (push_data)
  );

  mfrt_tile_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mfrt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tile_valid (pop_valid),
    .tile_ready (pop_ready),
    .tile       (pop_data),
    .columns    (columns)
  );

endmodule
